// ----- rtl/u8dc_pkg.sv -----
// Shared widths, limits and types for the UTF-8 decode and classify block.
`default_nettype none
package u8dc_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 3;
	localparam int CP_W   = 21;

	// sequence lengths
	localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;
	localparam logic [LEN_W-1:0] LEN_1   = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2   = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3   = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4   = 3'd4;

	// scalar value limits
	localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_MIN_2B   = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN_3B   = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN_4B   = 21'h010000;
	localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;

	typedef struct packed {
		logic ident_start;
		logic ident_continue;
		logic white_space;
	} class_t;

endpackage
`default_nettype wire

// ----- rtl/utf8_decode_classify.sv -----
// Top level: registered UTF-8 decoder with character classification.
//
// Present four source bytes on byte0..byte3 (byte0 is the lead byte at the
// current position) and raise start. A word is taken at each rising edge with
// start high and busy low; busy never rises, so one word per cycle is accepted.
// Each word yields one result: seq_length (1..4, or 0 for a bad lead byte, bad
// continuation, overlong form, surrogate or value above 0x10FFFF), code_point
// and the ident_start / ident_continue / white_space flags. On an invalid
// sequence code_point and all flags are 0; bytes past the sequence are ignored.
// A word lands in the input register when taken; decode and classify run in
// one combinational pass, and the result register captures their outputs; done
// is high for exactly one cycle per word while the result is shown. Throughput
// is one word per cycle, set by the single decode-plus-range-compare path
// between the two registers.
// arst_n low clears both valid flags at once; no result appears from words in
// flight. The payload registers have no reset.
// No back pressure: the receiver must take each result in its done cycle.
`default_nettype none
module utf8_decode_classify (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [u8dc_pkg::BYTE_W-1:0]  byte0,
	input  wire logic [u8dc_pkg::BYTE_W-1:0]  byte1,
	input  wire logic [u8dc_pkg::BYTE_W-1:0]  byte2,
	input  wire logic [u8dc_pkg::BYTE_W-1:0]  byte3,
	output logic                              done,
	output logic      [u8dc_pkg::LEN_W-1:0]   seq_length,
	output logic      [u8dc_pkg::CP_W-1:0]    code_point,
	output logic                              ident_start,
	output logic                              ident_continue,
	output logic                              white_space
);

	// stage 1: captured source bytes
	logic                          vld_s1;
	logic [u8dc_pkg::BYTE_W-1:0]   b0_s1, b1_s1, b2_s1, b3_s1;

	// decode / classify results feeding stage 2
	logic [u8dc_pkg::LEN_W-1:0]    len_d;
	logic [u8dc_pkg::CP_W-1:0]     cp_d;
	u8dc_pkg::class_t              cls_d;

	// stage 2: result register
	logic                          vld_s2;
	logic [u8dc_pkg::LEN_W-1:0]    len_s2;
	logic [u8dc_pkg::CP_W-1:0]     cp_s2;
	u8dc_pkg::class_t              cls_s2;

	// no iteration anywhere, so a new word is always welcome
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	// payload registers: no reset needed, qualified by the valid flags
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			b0_s1 <= byte0;
			b1_s1 <= byte1;
			b2_s1 <= byte2;
			b3_s1 <= byte3;
		end
		if (vld_s1) begin
			len_s2 <= len_d;
			cp_s2  <= cp_d;
			cls_s2 <= cls_d;
		end
	end

	u8dc_decode u_decode (
		.byte0      (b0_s1),
		.byte1      (b1_s1),
		.byte2      (b2_s1),
		.byte3      (b3_s1),
		.seq_length (len_d),
		.code_point (cp_d)
	);

	// an invalid sequence decodes to zero, which carries no flag
	u8dc_classify u_classify (
		.code_point (cp_d),
		.flags      (cls_d)
	);

	assign done           = vld_s2;
	assign seq_length     = len_s2;
	assign code_point     = cp_s2;
	assign ident_start    = cls_s2.ident_start;
	assign ident_continue = cls_s2.ident_continue;
	assign white_space    = cls_s2.white_space;

endmodule
`default_nettype wire

// ----- rtl/u8dc_decode.sv -----
// Single-pass UTF-8 sequence decoder: length and scalar value from four bytes.
`default_nettype none
module u8dc_decode (
	input  wire logic [u8dc_pkg::BYTE_W-1:0] byte0,
	input  wire logic [u8dc_pkg::BYTE_W-1:0] byte1,
	input  wire logic [u8dc_pkg::BYTE_W-1:0] byte2,
	input  wire logic [u8dc_pkg::BYTE_W-1:0] byte3,
	output logic      [u8dc_pkg::LEN_W-1:0]  seq_length,
	output logic      [u8dc_pkg::CP_W-1:0]   code_point
);

	logic                        c1_ok, c2_ok, c3_ok;
	logic [u8dc_pkg::CP_W-1:0]   cp2, cp3, cp4;

	assign c1_ok = (byte1[7:6] == 2'b10);
	assign c2_ok = (byte2[7:6] == 2'b10);
	assign c3_ok = (byte3[7:6] == 2'b10);

	assign cp2 = {10'd0, byte0[4:0], byte1[5:0]};
	assign cp3 = {5'd0, byte0[3:0], byte1[5:0], byte2[5:0]};
	assign cp4 = {byte0[2:0], byte1[5:0], byte2[5:0], byte3[5:0]};

	always_comb begin
		seq_length = u8dc_pkg::LEN_BAD;
		code_point = '0;
		unique case (byte0) inside
			8'b0???????: begin
				seq_length = u8dc_pkg::LEN_1;
				code_point = {13'd0, byte0};
			end
			8'b110?????: begin
				if (c1_ok && cp2 >= u8dc_pkg::CP_MIN_2B) begin
					seq_length = u8dc_pkg::LEN_2;
					code_point = cp2;
				end
			end
			8'b1110????: begin
				if (c1_ok && c2_ok && cp3 >= u8dc_pkg::CP_MIN_3B &&
				    !(cp3 >= u8dc_pkg::CP_SURR_LO && cp3 <= u8dc_pkg::CP_SURR_HI)) begin
					seq_length = u8dc_pkg::LEN_3;
					code_point = cp3;
				end
			end
			8'b11110???: begin
				if (c1_ok && c2_ok && c3_ok && cp4 >= u8dc_pkg::CP_MIN_4B &&
				    cp4 <= u8dc_pkg::CP_MAX) begin
					seq_length = u8dc_pkg::LEN_4;
					code_point = cp4;
				end
			end
			default: begin
				seq_length = u8dc_pkg::LEN_BAD;
				code_point = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/u8dc_classify.sv -----
// Range-table classification of a scalar value: identifier start/continue, whitespace.
`default_nettype none
module u8dc_classify (
	input  wire logic [u8dc_pkg::CP_W-1:0] code_point,
	output u8dc_pkg::class_t              flags
);

	function automatic logic in_rng(input logic [u8dc_pkg::CP_W-1:0] c,
	                                input logic [u8dc_pkg::CP_W-1:0] lo,
	                                input logic [u8dc_pkg::CP_W-1:0] hi);
		return (c >= lo) && (c <= hi);
	endfunction

	logic ascii, letter, digit, start_hi, cont_hi, space_lo, space_hi;

	assign ascii  = (code_point[u8dc_pkg::CP_W-1:7] == '0);
	assign letter = in_rng(code_point, 21'h61, 21'h7A) || in_rng(code_point, 21'h41, 21'h5A) ||
	                (code_point == 21'h5F);
	assign digit  = in_rng(code_point, 21'h30, 21'h39);

	assign start_hi =
		in_rng(code_point, 21'h00C0, 21'h00D6) || in_rng(code_point, 21'h00D8, 21'h00F6) ||
		in_rng(code_point, 21'h00F8, 21'h02FF) || in_rng(code_point, 21'h0370, 21'h037D) ||
		in_rng(code_point, 21'h037F, 21'h1FFF) || in_rng(code_point, 21'h200C, 21'h200D) ||
		in_rng(code_point, 21'h2070, 21'h218F) || in_rng(code_point, 21'h2C00, 21'h2FEF) ||
		in_rng(code_point, 21'h3001, 21'hD7FF) || in_rng(code_point, 21'hF900, 21'hFDCF) ||
		in_rng(code_point, 21'hFDF0, 21'hFFFD) || in_rng(code_point, 21'h10000, 21'hEFFFF);

	// combining marks, connector punctuation and the non-ASCII digit blocks
	assign cont_hi = start_hi ||
		in_rng(code_point, 21'h0300, 21'h036F) || in_rng(code_point, 21'h203F, 21'h2040) ||
		in_rng(code_point, 21'h0660, 21'h0669) || in_rng(code_point, 21'h06F0, 21'h06F9) ||
		in_rng(code_point, 21'h0966, 21'h096F) || in_rng(code_point, 21'hFF10, 21'hFF19);

	assign space_lo = (code_point == 21'h20) || in_rng(code_point, 21'h09, 21'h0D);
	assign space_hi =
		(code_point == 21'h0085) || (code_point == 21'h00A0) || (code_point == 21'h1680) ||
		in_rng(code_point, 21'h2000, 21'h200A) || (code_point == 21'h2028) ||
		(code_point == 21'h2029) || (code_point == 21'h202F) || (code_point == 21'h205F) ||
		(code_point == 21'h3000);

	assign flags.ident_start    = ascii ? letter : start_hi;
	assign flags.ident_continue = ascii ? (letter || digit) : cont_hi;
	assign flags.white_space    = ascii ? space_lo : space_hi;

endmodule
`default_nettype wire

// ----- rtl/u8dc_checker.sv -----
// Port-level assertions for the UTF-8 decode and classify block, with bind.
`default_nettype none
module u8dc_assert (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        done,
	input wire logic [u8dc_pkg::LEN_W-1:0]  seq_length,
	input wire logic [u8dc_pkg::CP_W-1:0]   code_point,
	input wire logic                        ident_start,
	input wire logic                        ident_continue,
	input wire logic                        white_space
);

	// exactly one result per accepted word, after the input and result registers
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy && arst_n, 2))
		else $error("result strobe does not track accepted words");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && seq_length == u8dc_pkg::LEN_BAD |->
		code_point == '0 && !ident_start && !ident_continue && !white_space)
		else $error("invalid sequence reports nonzero fields");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> seq_length <= u8dc_pkg::LEN_4 && code_point <= u8dc_pkg::CP_MAX)
		else $error("length or code point out of range");

	a_single_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		done && seq_length == u8dc_pkg::LEN_1 |-> code_point[u8dc_pkg::CP_W-1:7] == '0)
		else $error("one-byte sequence above ASCII");

	// ogham space mark is both a start character and whitespace
	a_start_implies_cont: assert property (@(posedge clk) disable iff (!arst_n)
		done && ident_start |-> ident_continue)
		else $error("inconsistent class flags");

endmodule

bind utf8_decode_classify u8dc_assert u_checker (.*);
`default_nettype wire
